### rtl/core/iprc_pkg.sv
// shared types and constants for the ip range rule table checker
// used by iprc_store and ip_range_rule_table_checker_top
package iprc_pkg;

  localparam int DEF_MAX_RULES = 64;
  localparam int ADDR_W        = 32;
  localparam int TAG_W         = 13;
  localparam int COUNT_W       = 11;
  localparam int TAG_LIMIT     = 4096;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [ADDR_W-1:0] high;
    logic [ADDR_W-1:0] low;
  } rule_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_REVERSED = 3'd1,
    ST_OVERLAP  = 3'd2,
    ST_TAG      = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_REV_RD,
    S_REV_EV,
    S_OVL_RI,
    S_OVL_LI,
    S_OVL_RJ,
    S_OVL_C1,
    S_OVL_C2,
    S_TAG_RD,
    S_TAG_EV,
    S_FIN
  } state_t;

endpackage

### rtl/core/iprc_store.sv
// rule table memory: one write port, one registered read port
// depends on iprc_pkg for rule_t
module iprc_store
  import iprc_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_RULES
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  rule_t                    wr_rule,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output rule_t                    rd_rule
);

  rule_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rule;
    end
  end

  // read data holds between reads, the sequencer relies on that
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_rule <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/ip_range_rule_table_checker_top.sv
// top level of the ip range rule table checker: rule loading, check sequencer,
// shared comparator and result register; depends on iprc_pkg and iprc_store
//
// Rules are taken one beat per cycle while the block is loading. The beat with
// tlast starts the check, and s_tready stays low until the result is placed in
// the output register. For n stored rules the check runs a reversed-range pass
// that reads and tests each rule, an overlap pass that reads each of the first
// n-1 rules and then tests it against every later rule (n(n-1)/2 pairs), and a
// tag pass that reads and tests each rule, stopping after the first pass that
// finds errors, then posts the result once the output register is free (an
// unread result holds the block there); an overflowed table skips the passes and
// goes straight to posting. The passes run one read and one test at a time on
// the single read port of the rule memory and the one 32-bit comparator that
// every test goes through. The rule memory needs no clearing after reset.
module ip_range_rule_table_checker_top
  import iprc_pkg::*;
#(
  parameter int MAX_RULES = DEF_MAX_RULES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // range_low[31:0], range_high[63:32], vlan_tag[76:64]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // status[2:0], error_count[13:3]
);

  localparam int IDX_W = $clog2(MAX_RULES);
  localparam int CNT_W = $clog2(MAX_RULES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_RULES);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
  localparam logic [ADDR_W-1:0] TAG_BAD_MIN = ADDR_W'(TAG_LIMIT + 1);

  state_t state, state_next;

  logic [CNT_W-1:0]   rule_count;
  logic               overflow_flag;
  logic [CNT_W-1:0]   n_rules;
  logic [CNT_W-1:0]   idx_i;
  logic [CNT_W-1:0]   idx_j;
  logic [ADDR_W-1:0]  low_i;
  logic [ADDR_W-1:0]  high_i;
  logic               c1;
  logic [COUNT_W-1:0] fault_tally;
  status_t            status;
  logic [15:0]        m_data;

  rule_t            in_rule;
  rule_t            rd_rule;
  logic             in_acc;
  logic             wr_en;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [ADDR_W-1:0] cmp_a;
  logic [ADDR_W-1:0] cmp_b;
  logic             cmp_ge;
  logic             hit;
  logic             cnt_nz;
  logic             table_full;
  logic             last_i;
  logic             last_j;
  logic             last_row;
  logic             out_free;

  assign in_rule.low  = s_tdata[31:0];
  assign in_rule.high = s_tdata[63:32];
  assign in_rule.tag  = s_tdata[76:64];

  assign in_acc     = s_tvalid & s_tready;
  assign table_full = (rule_count == CNT_FULL);
  assign wr_en      = in_acc & ~table_full;
  assign last_i     = (idx_i == n_rules - CNT_ONE);
  assign last_j     = (idx_j == n_rules - CNT_ONE);
  assign last_row   = (idx_i == n_rules - CNT_TWO);
  assign out_free   = ~m_tvalid | m_tready;
  assign cnt_nz     = (fault_tally != '0) | hit;

  assign cmp_ge = (cmp_a >= cmp_b);

  iprc_store #(
    .DEPTH (MAX_RULES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (rule_count[IDX_W-1:0]),
    .wr_rule (in_rule),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_rule (rd_rule)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_LOAD: begin
        if (in_acc && s_tlast) begin
          state_next = (overflow_flag || table_full) ? S_FIN : S_REV_RD;
        end
      end
      S_REV_RD: state_next = S_REV_EV;
      S_REV_EV: begin
        if (!last_i) begin
          state_next = S_REV_RD;
        end else if (cnt_nz) begin
          state_next = S_FIN;
        end else if (n_rules == CNT_ONE) begin
          state_next = S_TAG_RD;
        end else begin
          state_next = S_OVL_RI;
        end
      end
      S_OVL_RI: state_next = S_OVL_LI;
      S_OVL_LI: state_next = S_OVL_RJ;
      S_OVL_RJ: state_next = S_OVL_C1;
      S_OVL_C1: state_next = S_OVL_C2;
      S_OVL_C2: begin
        if (!last_j) begin
          state_next = S_OVL_RJ;
        end else if (!last_row) begin
          state_next = S_OVL_RI;
        end else if (cnt_nz) begin
          state_next = S_FIN;
        end else begin
          state_next = S_TAG_RD;
        end
      end
      S_TAG_RD: state_next = S_TAG_EV;
      S_TAG_EV: state_next = last_i ? S_FIN : S_TAG_RD;
      S_FIN: begin
        if (out_free) begin
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  // sequencer outputs and comparator operand select
  always_comb begin
    s_tready = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = idx_i[IDX_W-1:0];
    cmp_a    = rd_rule.high;
    cmp_b    = rd_rule.low;
    hit      = 1'b0;
    case (state)
      S_LOAD:   s_tready = 1'b1;
      S_REV_RD: rd_en = 1'b1;
      S_REV_EV: hit = ~cmp_ge;
      S_OVL_RI: rd_en = 1'b1;
      S_OVL_RJ: begin
        rd_en   = 1'b1;
        rd_addr = idx_j[IDX_W-1:0];
      end
      S_OVL_C1: begin
        cmp_a = high_i;
        cmp_b = rd_rule.low;
      end
      S_OVL_C2: begin
        cmp_a = rd_rule.high;
        cmp_b = low_i;
        hit   = c1 & cmp_ge;
      end
      S_TAG_RD: rd_en = 1'b1;
      S_TAG_EV: begin
        cmp_a = {{(ADDR_W-TAG_W){1'b0}}, rd_rule.tag};
        cmp_b = TAG_BAD_MIN;
        hit   = cmp_ge;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // table fill control
  always_ff @(posedge clk) begin
    if (rst) begin
      rule_count    <= '0;
      overflow_flag <= 1'b0;
    end else if (in_acc) begin
      if (s_tlast) begin
        rule_count    <= '0;
        overflow_flag <= 1'b0;
      end else if (table_full) begin
        overflow_flag <= 1'b1;
      end else begin
        rule_count <= rule_count + CNT_ONE;
      end
    end
  end

  // check datapath
  always_ff @(posedge clk) begin
    if (hit && fault_tally != COUNT_MAX) begin
      fault_tally <= fault_tally + COUNT_W'(1);
    end
    case (state)
      S_LOAD: begin
        if (in_acc && s_tlast) begin
          n_rules     <= table_full ? rule_count : rule_count + CNT_ONE;
          fault_tally <= '0;
          idx_i       <= '0;
          status      <= (overflow_flag || table_full) ? ST_OVERFLOW : ST_OK;
        end
      end
      S_REV_EV: begin
        if (!last_i) begin
          idx_i <= idx_i + CNT_ONE;
        end else if (cnt_nz) begin
          status <= ST_REVERSED;
        end else begin
          idx_i <= '0;
          idx_j <= CNT_ONE;
        end
      end
      S_OVL_LI: begin
        low_i  <= rd_rule.low;
        high_i <= rd_rule.high;
      end
      S_OVL_C1: c1 <= cmp_ge;
      S_OVL_C2: begin
        if (!last_j) begin
          idx_j <= idx_j + CNT_ONE;
        end else if (!last_row) begin
          idx_i <= idx_i + CNT_ONE;
          idx_j <= idx_i + CNT_TWO;
        end else if (cnt_nz) begin
          status <= ST_OVERLAP;
        end else begin
          idx_i <= '0;
        end
      end
      S_TAG_EV: begin
        if (!last_i) begin
          idx_i <= idx_i + CNT_ONE;
        end else if (cnt_nz) begin
          status <= ST_TAG;
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      m_data <= {2'b00, fault_tally, status};
    end
  end

  assign m_tdata = m_data;

  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    rule_count <= CNT_FULL)
    else $error("rule count beyond table depth");

  a_busy_after_last : assert property (@(posedge clk) disable iff (rst)
    in_acc && s_tlast |=> !s_tready)
    else $error("input taken during table check");

  a_ok_zero_count : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] == ST_OK || m_tdata[2:0] == ST_OVERFLOW)
      |-> m_tdata[13:3] == '0)
    else $error("nonzero error count with ok or overflow status");

  a_err_status : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] == ST_REVERSED || m_tdata[2:0] == ST_OVERLAP ||
      m_tdata[2:0] == ST_TAG) |-> m_tdata[13:3] != '0)
    else $error("error status with zero count");

endmodule
